// ===== rtl/wfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfm_pkg
// Shared types and constants of the window focus MRU list.
// ----------------------------------------------------------------------------
package wfm_pkg;

  localparam int MAX_WINDOWS  = 16;
  localparam int ID_BITS      = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int IDX_W        = $clog2(MAX_WINDOWS);
  localparam int CNT_W        = $clog2(MAX_WINDOWS + 1);

  typedef enum logic [3:0] {
    REQ_ADD      = 4'd0,
    REQ_REMOVE   = 4'd1,
    REQ_SWITCH   = 4'd2,
    REQ_SET_RD   = 4'd3,
    REQ_TOGGLE   = 4'd4,
    REQ_OPEN     = 4'd5,
    REQ_NEXT     = 4'd6,
    REQ_PREV     = 4'd7,
    REQ_CONFIRM  = 4'd8,
    REQ_CANCEL   = 4'd9,
    REQ_DNEXT    = 4'd10,
    REQ_DPREV    = 4'd11,
    REQ_LIST     = 4'd12
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FOCUSED = 3'd1,
    ST_NONE    = 3'd2,
    ST_FULL    = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONF_WAIT,
    S_DIR_WAIT,
    S_FIND_RD,
    S_FIND_CK,
    S_DEL_RD,
    S_DEL_WR,
    S_MTF_RD,
    S_MTF_WR,
    S_MTF_HEAD,
    S_COPY_RD,
    S_COPY_WR,
    S_LIST_RD,
    S_LIST_EM,
    S_RESP
  } state_e;

  typedef struct packed {
    logic               redraw;
    logic [ID_BITS-1:0] id;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/wfm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/window_focus_mru_list_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_focus_mru_list_top
// Most-recent-first window list with focus, redraw flags and a switcher.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Its results come
// back as beats on result_valid_o; the receiver cannot stall, so each beat
// must be taken in the cycle it shows. Every request gives one beat, except
// list, which gives one beat per entry (head first, last_item_o on the final
// one). The list lives in a 16-entry RAM with a registered read, and the
// switcher snapshot in a second RAM; every entry access is a read state
// followed by a compare or write state, so the single read port sets the
// rate. A search reads and compares one entry at a time; add, switch and
// remove then move entries one at a time, each with a read and a write state.
// Switcher open copies the list entry by entry, and list reads each entry
// before it emits its beat. The worst case is a confirm that brings the tail
// of a full list to the head.
// ----------------------------------------------------------------------------
module window_focus_mru_list_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [3:0]                req_type_i,
  input  wire logic [15:0]               window_id_i,
  input  wire logic                      redraw_value_i,
  output logic                           result_valid_o,
  output logic [2:0]                     status_o,
  output logic [15:0]                    focus_id_o,
  output logic                           focus_redraw_o,
  output logic                           overlay_on_o,
  output logic                           switcher_on_o,
  output logic [3:0]                     selected_pos_o,
  output logic [4:0]                     entry_count_o,
  output logic [15:0]                    listed_id_o,
  output logic                           last_item_o
);
  import wfm_pkg::*;

  state_e              state_q, state_d;
  req_e                op_q, op_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    live_q, live_d;
  logic [CNT_W-1:0]    snap_q, snap_d;
  logic [IDX_W-1:0]    sel_q, sel_d;
  logic                sw_q, sw_d;
  logic                ov_q, ov_d;
  entry_t              head_q, head_d;
  logic [ID_BITS-1:0]  key_q, key_d;
  entry_t              keep_q, keep_d;
  logic                rv_q, rv_d;
  status_e             status_q, status_d;

  // list RAM and snapshot RAM ports
  logic                o_we, s_we;
  logic [IDX_W-1:0]    o_waddr, o_raddr, s_waddr, s_raddr;
  entry_t              o_wdata, o_rdata;
  logic [ID_BITS-1:0]  s_wdata, s_rdata;

  logic                accept;
  logic                hit;
  logic [CNT_W-1:0]    list_n;
  logic [IDX_W-1:0]    sel_fix;
  logic [ID_BITS-1:0]  req_id;

  assign accept  = start_i && (state_q == S_IDLE);
  assign hit     = (o_rdata.id == key_q);
  assign list_n  = (live_q < CNT_W'(RESULT_LIMIT)) ? live_q : CNT_W'(RESULT_LIMIT);
  assign sel_fix = (CNT_W'(sel_q) >= snap_q) ? '0 : sel_q;
  assign req_id  = window_id_i[ID_BITS-1:0];

  wfm_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_WINDOWS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr),
    .wdata_i (o_wdata),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata)
  );

  wfm_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_WINDOWS)) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            REQ_ADD: begin
              if (req_id == '0 || live_q >= CNT_W'(MAX_WINDOWS)) state_d = S_RESP;
              else if (live_q == '0) state_d = S_MTF_HEAD;
              else state_d = S_MTF_RD;
            end
            REQ_REMOVE, REQ_SWITCH, REQ_SET_RD: state_d = S_FIND_RD;
            REQ_OPEN: state_d = (live_q == '0) ? S_RESP : S_COPY_RD;
            REQ_CONFIRM: state_d = (sw_q && snap_q != '0) ? S_CONF_WAIT : S_RESP;
            REQ_DNEXT, REQ_DPREV: state_d = (live_q >= CNT_W'(2)) ? S_DIR_WAIT : S_RESP;
            REQ_LIST: state_d = (live_q == '0) ? S_RESP : S_LIST_RD;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_CONF_WAIT, S_DIR_WAIT: state_d = S_FIND_RD;
      S_FIND_RD: state_d = (idx_q >= live_q) ? S_RESP : S_FIND_CK;
      S_FIND_CK: begin
        if (!hit) begin
          state_d = S_FIND_RD;
        end else begin
          case (op_q)
            REQ_REMOVE: state_d = (idx_q + CNT_W'(1) < live_q) ? S_DEL_RD : S_RESP;
            REQ_SET_RD: state_d = S_RESP;
            default:    state_d = (idx_q == '0) ? S_RESP : S_MTF_RD;
          endcase
        end
      end
      S_DEL_RD:   state_d = S_DEL_WR;
      S_DEL_WR:   state_d = (idx_q + CNT_W'(1) < live_q) ? S_DEL_RD : S_RESP;
      S_MTF_RD:   state_d = S_MTF_WR;
      S_MTF_WR:   state_d = (idx_q == CNT_W'(1)) ? S_MTF_HEAD : S_MTF_RD;
      S_MTF_HEAD: state_d = S_RESP;
      S_COPY_RD:  state_d = S_COPY_WR;
      S_COPY_WR:  state_d = (idx_q + CNT_W'(1) == live_q) ? S_RESP : S_COPY_RD;
      S_LIST_RD:  state_d = S_LIST_EM;
      S_LIST_EM:  state_d = (idx_q + CNT_W'(1) == list_n) ? S_IDLE : S_LIST_RD;
      S_RESP:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath, memory control and state updates.
  always_comb begin
    op_d     = op_q;
    idx_d    = idx_q;
    live_d   = live_q;
    snap_d   = snap_q;
    sel_d    = sel_q;
    sw_d     = sw_q;
    ov_d     = ov_q;
    key_d    = key_q;
    keep_d   = keep_q;
    rv_d     = rv_q;
    status_d = status_q;
    o_we     = 1'b0;
    o_waddr  = idx_q[IDX_W-1:0];
    o_wdata  = o_rdata;
    o_raddr  = idx_q[IDX_W-1:0];
    s_we     = 1'b0;
    s_waddr  = idx_q[IDX_W-1:0];
    s_wdata  = o_rdata.id;
    s_raddr  = sel_fix;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = req_e'(req_type_i);
          key_d    = req_id;
          rv_d     = redraw_value_i;
          idx_d    = '0;
          status_d = ST_OK;
          case (req_type_i)
            REQ_ADD: begin
              if (req_id == '0) status_d = ST_IGNORED;
              else if (live_q >= CNT_W'(MAX_WINDOWS)) status_d = ST_FULL;
              else begin
                keep_d = '{redraw: 1'b1, id: req_id};
                idx_d  = live_q;
              end
            end
            REQ_TOGGLE: ov_d = ~ov_q;
            REQ_OPEN: begin
              if (live_q == '0) begin
                snap_d   = '0;
                status_d = ST_NONE;
              end
            end
            REQ_NEXT, REQ_PREV: begin
              if (!sw_q || snap_q == '0) status_d = ST_IGNORED;
              else if (req_type_i == REQ_NEXT) begin
                sel_d = (CNT_W'(sel_fix) + CNT_W'(1) == snap_q) ? '0 : sel_fix + IDX_W'(1);
              end else begin
                sel_d = (sel_fix == '0) ? IDX_W'(snap_q - CNT_W'(1)) : sel_fix - IDX_W'(1);
              end
            end
            REQ_CONFIRM: begin
              if (!sw_q) status_d = ST_IGNORED;
              else if (snap_q == '0) begin
                sw_d = 1'b0; snap_d = '0; sel_d = '0; ov_d = 1'b0;
                status_d = ST_NONE;
              end
            end
            REQ_CANCEL: begin
              if (!sw_q) status_d = ST_IGNORED;
              else begin
                sw_d = 1'b0; snap_d = '0; sel_d = '0; ov_d = 1'b0;
              end
            end
            REQ_DNEXT, REQ_DPREV: begin
              if (live_q == '0) status_d = ST_NONE;
              else if (live_q == CNT_W'(1)) status_d = ST_IGNORED;
              else if (req_type_i == REQ_DNEXT) o_raddr = IDX_W'(1);
              else o_raddr = IDX_W'(live_q - CNT_W'(1));
            end
            REQ_REMOVE, REQ_SWITCH, REQ_SET_RD: ;
            REQ_LIST: if (live_q == '0) status_d = ST_NONE;
            default: status_d = ST_IGNORED;
          endcase
        end
      end
      S_CONF_WAIT: key_d = s_rdata;
      S_DIR_WAIT:  key_d = o_rdata.id;
      S_FIND_RD: begin
        // running off the end of the list means no match
        if (idx_q >= live_q) begin
          status_d = ST_NONE;
          if (op_q == REQ_CONFIRM) begin
            sw_d = 1'b0; snap_d = '0; sel_d = '0; ov_d = 1'b0;
          end
        end
      end
      S_FIND_CK: begin
        if (!hit) begin
          idx_d = idx_q + CNT_W'(1);
        end else begin
          case (op_q)
            REQ_REMOVE: live_d = live_q - CNT_W'(1);
            REQ_SET_RD: begin
              o_we    = 1'b1;
              o_wdata = '{redraw: rv_q, id: o_rdata.id};
            end
            default: begin
              if (idx_q == '0) begin
                status_d = ST_FOCUSED;
                if (op_q == REQ_CONFIRM) begin
                  sw_d = 1'b0; snap_d = '0; sel_d = '0; ov_d = 1'b0;
                end
              end else begin
                keep_d = o_rdata;
              end
            end
          endcase
        end
      end
      S_DEL_RD: o_raddr = IDX_W'(idx_q + CNT_W'(1));
      S_DEL_WR: begin
        o_we  = 1'b1;
        idx_d = idx_q + CNT_W'(1);
      end
      S_MTF_RD: o_raddr = IDX_W'(idx_q - CNT_W'(1));
      S_MTF_WR: begin
        o_we  = 1'b1;
        idx_d = idx_q - CNT_W'(1);
      end
      S_MTF_HEAD: begin
        o_we    = 1'b1;
        o_waddr = '0;
        o_wdata = keep_q;
        if (op_q == REQ_ADD) live_d = live_q + CNT_W'(1);
        if (op_q == REQ_CONFIRM) begin
          sw_d = 1'b0; snap_d = '0; sel_d = '0; ov_d = 1'b0;
        end
      end
      S_COPY_WR: begin
        s_we  = 1'b1;
        idx_d = idx_q + CNT_W'(1);
        if (idx_q + CNT_W'(1) == live_q) begin
          snap_d = live_q;
          sw_d   = 1'b1;
          sel_d  = '0;
          ov_d   = 1'b1;
        end
      end
      S_LIST_EM: idx_d = idx_q + CNT_W'(1);
      default: ;
    endcase
  end

  // Shadow the head entry so focus is always at hand.
  always_comb begin
    head_d = head_q;
    if (o_we && o_waddr == '0) head_d = o_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      live_q  <= '0;
      snap_q  <= '0;
      sel_q   <= '0;
      sw_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      snap_q  <= snap_d;
      sel_q   <= sel_d;
      sw_q    <= sw_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    head_q   <= head_d;
    key_q    <= key_d;
    keep_q   <= keep_d;
    rv_q     <= rv_d;
    status_q <= status_d;
  end

  // Result beat: a response cycle or one list entry.
  always_comb begin
    busy_o         = (state_q != S_IDLE);
    result_valid_o = (state_q == S_RESP) || (state_q == S_LIST_EM);
    status_o       = (state_q == S_LIST_EM) ? ST_OK : status_q;
    focus_id_o     = (live_q != '0) ? 16'(head_q.id) : '0;
    focus_redraw_o = (live_q != '0) && head_q.redraw;
    overlay_on_o   = ov_q;
    switcher_on_o  = sw_q;
    selected_pos_o = sw_q ? 4'(sel_q) : '0;
    entry_count_o  = 5'(live_q);
    listed_id_o    = (state_q == S_LIST_EM) ? 16'(o_rdata.id) : '0;
    last_item_o    = (state_q == S_LIST_EM) ? (idx_q + CNT_W'(1) == list_n) : 1'b1;
  end

  // Drop out of idle on every accepted request.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("request accepted but block not busy");

  a_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result beat while idle");

  a_live_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(MAX_WINDOWS)) else $error("entry count beyond capacity");

  // An open on an empty list may leave the switcher on with an empty snapshot.
  a_switcher_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sw_q && snap_q != '0) |-> (CNT_W'(sel_q) < snap_q))
    else $error("switcher selection beyond snapshot");

endmodule
`default_nettype wire
